// ----- hdl/mbcs_pkg.sv -----
// Package: code page codes, register indexes, reset values and pipeline types
`default_nettype none
package mbcs_pkg;

	typedef enum logic [2:0] {
		CP_932 = 3'd0,
		CP_936 = 3'd1,
		CP_949 = 3'd2,
		CP_950 = 3'd3
	} code_page_t;

	typedef enum logic [2:0] {
		REG_CODE_PAGE   = 3'd0,
		REG_PROP_FONT   = 3'd1,
		REG_HEIGHT      = 3'd2,
		REG_HEADER      = 3'd3,
		REG_ENTRY_BYTES = 3'd4
	} reg_index_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned GIDX_W      = 15;
	localparam int unsigned GBYTES_W    = 13;
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned PROD_W      = GIDX_W + GBYTES_W;

	localparam logic [2:0]  RST_CODE_PAGE   = 3'd1;
	localparam logic        RST_PROP_FONT   = 1'b0;
	localparam logic [7:0]  RST_HEIGHT      = 8'd16;
	localparam logic [15:0] RST_HEADER      = 16'd16;
	localparam logic [4:0]  RST_ENTRY_BYTES = 5'd4;

	localparam logic [15:0] CP932_ROW_STRIDE = 16'd188;
	localparam logic [15:0] CP932_HIGH_BASE  = 16'd5828;
	localparam logic [15:0] CP936_ROW_STRIDE = 16'd94;
	localparam logic [15:0] CP949_ROW_STRIDE = 16'd188;
	localparam logic [15:0] CP950_ROW_STRIDE = 16'd157;
	localparam int unsigned MAX_GLYPH_INDEX  = 23875;

	typedef struct packed {
		logic              found;
		logic              kind;
		logic [GIDX_W-1:0] idx;
		logic [7:0]        code;
	} decode_t;

	typedef struct packed {
		logic              found;
		logic              kind;
		logic [GIDX_W-1:0] idx;
		logic [PROD_W-1:0] prod;
	} product_t;

endpackage
`default_nettype wire

// ----- hdl/mbcs_glyph_address_calc_top.sv -----
// Top level: multi-byte code page glyph address calculator, three-stage pipeline
//
// Usage:
//   Pulse start with char_code; an item is transferred at an edge with start
//   high and busy low. busy is always low, so one code may enter every cycle.
//   Stage 1 decodes row and cell for the selected code page into a dense
//   glyph index; stage 2 multiplies it by the glyph size (or the code by the
//   index entry size); stage 3 adds the header size and drives the results.
//   done is high for exactly one cycle, when the item leaves stage 3,
//   together with found, addr_kind, byte_address, pixel_width and glyph_index.
//   Throughput is one item per cycle, as no stage can stall. The receiver
//   cannot stall: each result is shown for one cycle only. Registers are
//   written over the cfg channel (cfg_ready is always high); the user writes
//   them only while no item is in flight, which the block does not enforce.
//   The glyph size register is loaded from the height register. Reset
//   empties the pipeline and loads the register reset values.
`default_nettype none
module mbcs_glyph_address_calc_top
	import mbcs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [15:0]            char_code,
	output logic                        done,
	output logic                        found,
	output logic                        addr_kind,
	output logic [ADDR_W-1:0]           byte_address,
	output logic [7:0]                  pixel_width,
	output logic [GIDX_W-1:0]           glyph_index,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [2:0]          code_page_q;
	logic                prop_font_q;
	logic [7:0]          glyph_height_q;
	logic [15:0]         header_bytes_q;
	logic [4:0]          entry_bytes_q;
	logic [GBYTES_W-1:0] glyph_bytes_q;

	logic     valid_s1, valid_s2, valid_s3;
	decode_t  item_s1;
	product_t item_s2;
	decode_t  dec;

	logic [7:0]  row, col;
	logic [15:0] base, offs;
	logic        row_ok, cell_ok;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign row       = char_code[15:8];
	assign col       = char_code[7:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_page_q    <= RST_CODE_PAGE;
			prop_font_q    <= RST_PROP_FONT;
			glyph_height_q <= RST_HEIGHT;
			header_bytes_q <= RST_HEADER;
			entry_bytes_q  <= RST_ENTRY_BYTES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CODE_PAGE:   code_page_q    <= cfg_data[2:0];
				REG_PROP_FONT:   prop_font_q    <= cfg_data[0];
				REG_HEIGHT:      glyph_height_q <= cfg_data[7:0];
				REG_HEADER:      header_bytes_q <= cfg_data;
				REG_ENTRY_BYTES: entry_bytes_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// bytes per glyph: ceil(height/8) * height
	always_ff @(posedge clk) begin
		glyph_bytes_q <= GBYTES_W'(({2'b00, glyph_height_q[7:3]} + 7'(|glyph_height_q[2:0]))
			* 13'(glyph_height_q));
	end

	// stage 1 decode
	always_comb begin
		base    = '0;
		offs    = '0;
		row_ok  = 1'b0;
		cell_ok = 1'b0;
		case (code_page_t'(code_page_q))
			CP_932: begin
				if (row >= 8'h81 && row <= 8'h9F) begin
					row_ok = 1'b1;
					base   = 16'(row - 8'h81) * CP932_ROW_STRIDE;
				end else if (row >= 8'hE0 && row <= 8'hFC) begin
					row_ok = 1'b1;
					base   = CP932_HIGH_BASE + 16'(row - 8'hE0) * CP932_ROW_STRIDE;
				end
				if (col >= 8'h40 && col <= 8'h7E) begin
					cell_ok = 1'b1;
					offs    = 16'(col - 8'h40);
				end else if (col >= 8'h80 && col <= 8'hFC) begin
					cell_ok = 1'b1;
					offs    = 16'(col - 8'h41);
				end
			end
			CP_936: begin
				row_ok  = row >= 8'hA1 && row <= 8'hFE;
				cell_ok = col >= 8'hA1 && col <= 8'hFE;
				base    = 16'(row - 8'hA1) * CP936_ROW_STRIDE;
				offs    = 16'(col - 8'hA1);
			end
			CP_949: begin
				row_ok = row >= 8'h81;
				base   = 16'(row - 8'h81) * CP949_ROW_STRIDE;
				if (col >= 8'h41 && col <= 8'h7E) begin
					cell_ok = 1'b1;
					offs    = 16'(col - 8'h41);
				end else if (col >= 8'h81 && col <= 8'hFE) begin
					cell_ok = 1'b1;
					offs    = 16'(col - 8'h43);
				end
			end
			CP_950: begin
				row_ok = row >= 8'hA1 && row <= 8'hFE;
				base   = 16'(row - 8'hA1) * CP950_ROW_STRIDE;
				if (col >= 8'h40 && col <= 8'h7E) begin
					cell_ok = 1'b1;
					offs    = 16'(col - 8'h40);
				end else if (col >= 8'hA1 && col <= 8'hFE) begin
					cell_ok = 1'b1;
					offs    = 16'(col - 8'h62);
				end
			end
			default: ;
		endcase
		dec.code = col;
		if (prop_font_q) begin
			dec.found = row == 8'h00;
			dec.kind  = 1'b1;
			dec.idx   = '0;
		end else begin
			dec.found = row_ok && cell_ok;
			dec.kind  = 1'b0;
			dec.idx   = GIDX_W'(base + offs);
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		item_s1 <= dec;

		item_s2.found <= item_s1.found;
		item_s2.kind  <= item_s1.kind;
		item_s2.idx   <= item_s1.idx;
		if (item_s1.kind)
			item_s2.prod <= PROD_W'(13'(item_s1.code) * 13'(entry_bytes_q));
		else
			item_s2.prod <= PROD_W'(item_s1.idx) * PROD_W'(glyph_bytes_q);

		found        <= item_s2.found;
		addr_kind    <= item_s2.found && item_s2.kind;
		byte_address <= item_s2.found
			? ADDR_W'(item_s2.prod) + ADDR_W'(header_bytes_q) : '0;
		pixel_width  <= (item_s2.found && !item_s2.kind) ? glyph_height_q : '0;
		glyph_index  <= (item_s2.found && !item_s2.kind) ? item_s2.idx : '0;
	end

	assign done = valid_s3;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing three cycles after transfer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> !addr_kind && byte_address == '0 && pixel_width == '0
			&& glyph_index == '0)
		else $error("not-found result carries non-zero fields");

	a_entry_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && addr_kind |-> found && pixel_width == '0 && glyph_index == '0)
		else $error("index entry result carries glyph fields");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && found && !addr_kind |-> glyph_index <= GIDX_W'(MAX_GLYPH_INDEX)
			&& byte_address >= ADDR_W'(header_bytes_q))
		else $error("glyph index or address out of range");
`endif

endmodule
`default_nettype wire

// ----- test/mbcs_glyph_address_calc_top_test.sv -----
// Testbench: self-checking stimulus and result prediction for the glyph address calculator
`default_nettype none
module mbcs_glyph_address_calc_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mbcs_pkg::*;

	localparam int unsigned PIPE_LATENCY = 3;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned RAND_PHASES  = 13;
	localparam int unsigned PHASE_CODES  = 150;

	localparam logic [2:0] CP_UNSUPPORTED_LO = 3'd4;
	localparam logic [2:0] CP_UNSUPPORTED_HI = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_ENTRY_BYTES + 1;

	localparam int unsigned CP932_LOW_CELLS = 63;
	localparam int unsigned CP949_LOW_CELLS = 62;
	localparam int unsigned CP950_LOW_CELLS = 63;

	typedef struct packed {
		logic              found;
		logic              addr_kind;
		logic [ADDR_W-1:0] byte_address;
		logic [7:0]        pixel_width;
		logic [GIDX_W-1:0] glyph_index;
	} glyph_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic [15:0]            char_code = '0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   busy;
	logic                   done;
	logic                   found;
	logic                   addr_kind;
	logic [ADDR_W-1:0]      byte_address;
	logic [7:0]             pixel_width;
	logic [GIDX_W-1:0]      glyph_index;
	logic                   cfg_ready;

	// predictor's copy of the registers
	logic [2:0]  cp_q        = RST_CODE_PAGE;
	logic        prop_q      = RST_PROP_FONT;
	logic [7:0]  height_q    = RST_HEIGHT;
	logic [15:0] header_q    = RST_HEADER;
	logic [4:0]  entry_q     = RST_ENTRY_BYTES;

	glyph_result_t pending_glyphs[$];
	int unsigned   codes_sent      = 0;
	int unsigned   results_checked = 0;
	int unsigned   glyph_hits      = 0;
	int unsigned   settings_count  = 0;
	int unsigned   mismatches      = 0;
	int unsigned   stall_cycles    = 0;

	mbcs_glyph_address_calc_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.char_code    (char_code),
		.done         (done),
		.found        (found),
		.addr_kind    (addr_kind),
		.byte_address (byte_address),
		.pixel_width  (pixel_width),
		.glyph_index  (glyph_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic glyph_result_t predict_glyph(input logic [15:0] code);
		glyph_result_t res;
		int unsigned   row;
		int unsigned   col;
		int unsigned   base;
		int unsigned   idx;
		int unsigned   glyph_bytes;
		bit            row_ok;
		bit            hit;
		res    = '0;
		row    = 32'(code[15:8]);
		col    = 32'(code[7:0]);
		base   = 0;
		idx    = 0;
		row_ok = 1'b0;
		hit    = 1'b0;
		if (!prop_q) begin
			case (cp_q)
				CP_932: begin
					if (row >= 'h81 && row <= 'h9F) begin
						row_ok = 1'b1;
						base   = (row - 'h81) * CP932_ROW_STRIDE;
					end else if (row >= 'hE0 && row <= 'hFC) begin
						row_ok = 1'b1;
						base   = CP932_HIGH_BASE + (row - 'hE0) * CP932_ROW_STRIDE;
					end
					if (row_ok && col >= 'h40 && col <= 'h7E) begin
						hit = 1'b1;
						idx = base + col - 'h40;
					end else if (row_ok && col >= 'h80 && col <= 'hFC) begin
						hit = 1'b1;
						idx = base + col - 'h80 + CP932_LOW_CELLS;
					end
				end
				CP_936: begin
					if (row >= 'hA1 && row <= 'hFE && col >= 'hA1 && col <= 'hFE) begin
						hit = 1'b1;
						idx = (row - 'hA1) * CP936_ROW_STRIDE + col - 'hA1;
					end
				end
				CP_949: begin
					if (row >= 'h81) begin
						base = (row - 'h81) * CP949_ROW_STRIDE;
						if (col >= 'h41 && col <= 'h7E) begin
							hit = 1'b1;
							idx = base + col - 'h41;
						end else if (col >= 'h81 && col <= 'hFE) begin
							hit = 1'b1;
							idx = base + col - 'h81 + CP949_LOW_CELLS;
						end
					end
				end
				CP_950: begin
					if (row >= 'hA1 && row <= 'hFE) begin
						base = (row - 'hA1) * CP950_ROW_STRIDE;
						if (col >= 'h40 && col <= 'h7E) begin
							hit = 1'b1;
							idx = base + col - 'h40;
						end else if (col >= 'hA1 && col <= 'hFE) begin
							hit = 1'b1;
							idx = base + col - 'hA1 + CP950_LOW_CELLS;
						end
					end
				end
				default: hit = 1'b0;
			endcase
			if (hit) begin
				glyph_bytes      = ((32'(height_q) + 7) / 8) * 32'(height_q);
				res.found        = 1'b1;
				res.byte_address = 32'(header_q) + idx * glyph_bytes;
				res.pixel_width  = height_q;
				res.glyph_index  = idx[GIDX_W-1:0];
			end
		end else if (code <= 16'h00FF) begin
			res.found        = 1'b1;
			res.addr_kind    = 1'b1;
			res.byte_address = 32'(header_q) + 32'(code) * 32'(entry_q);
		end
		return res;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : scoreboard
		glyph_result_t want;
		bit            moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				moved = 1'b1;
				results_checked++;
				if (pending_glyphs.size() == 0) begin
					$display("%0t: result with no code pending, address 0x%0h", $time,
						byte_address);
					mismatches++;
				end else begin
					want = pending_glyphs.pop_front();
					check_field("found", want.found, found);
					check_field("addr_kind", want.addr_kind, addr_kind);
					check_field("byte_address", want.byte_address, byte_address);
					check_field("pixel_width", want.pixel_width, pixel_width);
					check_field("glyph_index", want.glyph_index, glyph_index);
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				want  = predict_glyph(char_code);
				if (want.found)
					glyph_hits++;
				pending_glyphs.push_back(want);
				codes_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_CODE_PAGE:   cp_q     = cfg_data[2:0];
					REG_PROP_FONT:   prop_q   = cfg_data[0];
					REG_HEIGHT:      height_q = cfg_data[7:0];
					REG_HEADER:      header_q = cfg_data[15:0];
					REG_ENTRY_BYTES: entry_q  = cfg_data[4:0];
					default: ;
				endcase
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_code(input logic [15:0] code);
		start     <= 1'b1;
		char_code <= code;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// drop start, then hold until every result is back and the pipe is empty
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [2:0] page, input logic prop,
			input logic [15:0] height_word, input logic [15:0] header,
			input logic [15:0] entry_word);
		quiesce();
		cfg_write(REG_CODE_PAGE, {13'($urandom), page});
		cfg_write(REG_PROP_FONT, {15'($urandom), prop});
		cfg_write(REG_HEIGHT, height_word);
		cfg_write(REG_HEADER, header);
		cfg_write(REG_ENTRY_BYTES, entry_word);
		cfg_close();
		settings_count++;
	endtask

	task automatic random_settings();
		logic [2:0]  page;
		logic [7:0]  height;
		logic [15:0] header;
		logic [4:0]  entry;
		if ($urandom_range(0, 4) == 0)
			page = 3'($urandom_range(CP_UNSUPPORTED_LO, CP_UNSUPPORTED_HI));
		else
			page = 3'($urandom_range(CP_932, CP_950));
		case ($urandom_range(0, 5))
			0: height = 8'd0;
			1: height = 8'd1;
			2: height = 8'd255;
			3: height = 8'd8;
			default: height = 8'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: header = 16'h0000;
			1: header = 16'hFFFF;
			default: header = 16'($urandom);
		endcase
		case ($urandom_range(0, 6))
			0: entry = 5'd1;
			1: entry = 5'd16;
			2: entry = 5'd0;
			3: entry = 5'd31;
			default: entry = 5'($urandom_range(1, 16));
		endcase
		apply_settings(page, $urandom_range(0, 3) == 0, {8'($urandom), height}, header,
			{11'($urandom), entry});
	endtask

	function automatic logic [15:0] valid_code(input logic [2:0] page);
		logic [7:0] row;
		logic [7:0] col;
		row = 8'($urandom);
		col = 8'($urandom);
		case (page)
			CP_932: begin
				row = $urandom_range(0, 1) ? 8'($urandom_range('h81, 'h9F))
					: 8'($urandom_range('hE0, 'hFC));
				col = $urandom_range(0, 1) ? 8'($urandom_range('h40, 'h7E))
					: 8'($urandom_range('h80, 'hFC));
			end
			CP_936: begin
				row = 8'($urandom_range('hA1, 'hFE));
				col = 8'($urandom_range('hA1, 'hFE));
			end
			CP_949: begin
				row = 8'($urandom_range('h81, 'hFF));
				col = $urandom_range(0, 1) ? 8'($urandom_range('h41, 'h7E))
					: 8'($urandom_range('h81, 'hFE));
			end
			CP_950: begin
				row = 8'($urandom_range('hA1, 'hFE));
				col = $urandom_range(0, 1) ? 8'($urandom_range('h40, 'h7E))
					: 8'($urandom_range('hA1, 'hFE));
			end
			default: ;
		endcase
		return {row, col};
	endfunction

	function automatic logic [15:0] pick_code();
		if (prop_q)
			return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 255)) : 16'($urandom);
		if (cp_q <= CP_950 && $urandom_range(0, 99) < 65)
			return valid_code(cp_q);
		return 16'($urandom);
	endfunction

	task automatic test_reset_defaults();
		send_code(16'hA1A1);
		send_code(16'hFEFE);
		send_code(16'hA0A1);
		send_code(16'hA1FF);
	endtask

	task automatic test_code_page_edges();
		apply_settings(CP_932, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0010);
		send_code(16'h8140);
		send_code(16'hFCFC);
		send_code(16'h817F);
		send_code(16'hA040);
		apply_settings(CP_949, 1'b0, 16'h0001, 16'h0000, 16'h0004);
		send_code(16'h8141);
		send_code(16'hFFFE);
		send_code(16'h8080);
		send_code(16'h8180);
		apply_settings(CP_950, 1'b0, 16'h0100, 16'h1234, 16'h0004);
		send_code(16'hA140);
		send_code(16'hFEFE);
		send_code(16'hA17F);
	endtask

	task automatic test_unsupported_pages();
		apply_settings(CP_UNSUPPORTED_LO, 1'b0, 16'h0010, 16'h0010, 16'h0004);
		send_code(16'h8140);
		apply_settings(CP_UNSUPPORTED_HI, 1'b0, 16'h0010, 16'h0010, 16'h0004);
		send_code(16'hA1A1);
	endtask

	task automatic test_index_table();
		apply_settings(CP_936, 1'b1, 16'h0010, 16'hFFFF, 16'h0010);
		send_code(16'h0000);
		send_code(16'h00FF);
		send_code(16'h0100);
		send_code(16'hFFFF);
		apply_settings(CP_936, 1'b1, 16'h0010, 16'h0020, 16'hFFE0);
		send_code(16'h00FF);
		apply_settings(CP_936, 1'b1, 16'h0010, 16'h0020, 16'h001F);
		send_code(16'h00FF);
	endtask

	// writes past the last register must leave every setting alone
	task automatic test_spare_registers();
		logic [CFG_INDEX_W-1:0] idx;
		quiesce();
		idx = REG_SPARE_LO;
		do begin
			cfg_write(idx, 16'hFFFF);
			idx++;
		end while (idx != 0);
		cfg_close();
		send_code(16'h0080);
	endtask

	task automatic test_random_traffic();
		for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
			random_settings();
			for (int unsigned n = 0; n < PHASE_CODES; n++) begin
				send_code(pick_code());
				if ((phase == 1 && n == PHASE_CODES / 2) || $urandom_range(0, 299) == 0)
					quiesce();
				else if (phase % 4 != 3)
					pause_sender(gap_len());
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_code_page_edges();
		test_unsupported_pages();
		test_index_table();
		test_spare_registers();
		test_random_traffic();
		quiesce();
		$display("Checked %0d results from %0d codes under %0d register settings (%0d hits)",
			results_checked, codes_sent, settings_count, glyph_hits);
		$display("Covered code pages 932/936/949/950, unsupported pages and index-table lookups");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
